/* src/bzr_pkg.sv */
package bzr_pkg;

  // Default sizes of the bitmap and the chunk table
  localparam int DEF_MAX_BITS   = 65536;
  localparam int DEF_MAX_CHUNKS = 256;

  // Register value after reset
  localparam int N_BITS_RESET   = 65536;

  // Field widths on the ports
  localparam int FUNC_W      = 2;
  localparam int BIDX_W      = 13;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 17;
  localparam int CIDX_W      = 8;
  localparam int COUNT_W     = 17;
  localparam int STATUS_W    = 2;
  localparam int NBITS_W     = 17;
  localparam int NCHUNKS_W   = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_RANK  = 2'd2,
    FUNC_CHUNK = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_POS_RANGE   = 2'd1,
    ST_CHUNK_RANGE = 2'd2,
    ST_NOT_BUILT   = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_N_BITS   = 1'b0,
    CFG_N_CHUNKS = 1'b1
  } cfg_reg_t;

  // Operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_BITS_BY_CHUNKS,
    DIV_BITS_BY_SIZE,
    DIV_POS_BY_SIZE
  } div_op_t;

  // Read address selection for the prefix table
  typedef enum logic [1:0] {
    PF_RANK,
    PF_CHUNK_HI,
    PF_CHUNK_LO
  } pf_sel_t;

  // Source of the count loaded into the output register
  typedef enum logic [1:0] {
    OUT_ACC,
    OUT_DIFF,
    OUT_ZERO
  } out_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     cfg_write;
    logic     accept;
    logic     div_start;
    div_op_t  div_op;
    logic     set_size;
    logic     set_total;
    logic     build_init;
    logic     rank_init;
    logic     acc_load;
    logic     byte_read;
    logic     step;
    logic     pf_read;
    pf_sel_t  pf_sel;
    logic     hold_load;
    logic     set_built;
    logic     out_load;
    out_sel_t out_sel;
    status_t  out_status;
  } bzr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  built;
    logic  pos_bad;
    logic  chunk_bad;
    logic  div_done;
    logic  sweep_empty;
    logic  step_final;
  } bzr_stat_t;

endpackage

/* src/bzr_div.sv */
module bzr_div
  import bzr_pkg::*;
#(
  parameter int WIDTH = COUNT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // Trial subtraction of one restoring step
  always_comb begin
    shifted = {rem, quot[WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    fits    = !diff[WIDTH];
  end

  // Count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quot <= {quot[WIDTH-2:0], fits};
    end
  end

endmodule

/* src/bzr_dp.sv */
module bzr_dp
  import bzr_pkg::*;
#(
  parameter int MAX_BITS   = DEF_MAX_BITS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bzr_cmd_t               cmd,
  output bzr_stat_t              stat,
  input  logic [FUNC_W-1:0]      func,
  input  logic [BIDX_W-1:0]      byte_index,
  input  logic [BYTE_W-1:0]      byte_value,
  input  logic [POS_W-1:0]       pos,
  input  logic [CIDX_W-1:0]      chunk_index,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [COUNT_W-1:0]     zero_count,
  output logic [STATUS_W-1:0]    status
);

  localparam int BIT_W       = $clog2(MAX_BITS + 1);
  localparam int CHUNK_W     = $clog2(MAX_CHUNKS + 1);
  localparam int DIV_W       = (BIT_W > CHUNK_W) ? BIT_W : CHUNK_W;
  localparam int STORE_BYTES = (MAX_BITS + BYTE_W - 1) / BYTE_W;
  localparam int BADDR_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PF_DEPTH    = MAX_CHUNKS + 1;
  localparam int NB_RESET    = (MAX_BITS < N_BITS_RESET) ? MAX_BITS : N_BITS_RESET;
  localparam int LANE_W      = $clog2(BYTE_W);
  localparam int SPAN_W      = $clog2(BYTE_W + 1);

  // Bitmap bytes and chunk prefix counts
  logic [BYTE_W-1:0] byte_mem [STORE_BYTES];
  logic [BIT_W-1:0]  pf_mem   [PF_DEPTH];

  // Effective register values and build results
  logic [BIT_W-1:0]   nb;
  logic [CHUNK_W-1:0] nc;
  logic [BIT_W-1:0]   cb;
  logic [CHUNK_W-1:0] total;
  logic               built;

  // Captured item
  func_t              func_q;
  logic [POS_W-1:0]   pos_q;
  logic [CIDX_W-1:0]  cidx_q;

  // Sweep state
  logic [BIT_W-1:0]   p;
  logic [BIT_W-1:0]   lim;
  logic [BIT_W-1:0]   acc;
  logic [CHUNK_W-1:0] ci;
  logic [BIT_W-1:0]   hold;
  logic [BYTE_W-1:0]  rd_byte;
  logic [BIT_W-1:0]   pf_rd;

  logic [BIT_W-1:0]   nb_new;
  logic [CHUNK_W-1:0] nc_new;
  logic [NBITS_W-1:0] nbits_raw;
  logic [NCHUNKS_W-1:0] nchunks_raw;

  logic [DIV_W-1:0]   div_a;
  logic [DIV_W-1:0]   div_b;
  logic [DIV_W-1:0]   quot;
  logic [DIV_W-1:0]   rem;
  logic               div_done;
  logic [DIV_W-1:0]   ceil_q;

  logic [BIT_W-1:0]   byte_base;
  logic [BIT_W:0]     seg_top;
  logic [BIT_W:0]     q_x;
  logic [BIT_W-1:0]   q;
  logic [LANE_W-1:0]  lane;
  logic [SPAN_W-1:0]  span;
  logic [SPAN_W-1:0]  cnt;
  logic [BIT_W-1:0]   acc_sum;
  logic [BIT_W:0]     next_lim_x;
  logic [BIT_W-1:0]   next_lim;
  logic               chunk_end;
  logic               chunk_write;

  logic               pf_we;
  logic [CHUNK_W-1:0] pf_waddr;
  logic [BIT_W-1:0]   pf_wdata;
  logic [CHUNK_W-1:0] pf_raddr;
  logic [BIT_W-1:0]   out_val;

  // Clamp register writes to their usable range
  always_comb begin
    nbits_raw   = cfg_data[NBITS_W-1:0];
    nchunks_raw = cfg_data[NCHUNKS_W-1:0];
    if (nbits_raw == '0) begin
      nb_new = BIT_W'(1);
    end else if (32'(nbits_raw) > 32'(MAX_BITS)) begin
      nb_new = BIT_W'(MAX_BITS);
    end else begin
      nb_new = BIT_W'(nbits_raw);
    end
    if (nchunks_raw == '0) begin
      nc_new = CHUNK_W'(1);
    end else if (32'(nchunks_raw) > 32'(MAX_CHUNKS)) begin
      nc_new = CHUNK_W'(MAX_CHUNKS);
    end else begin
      nc_new = CHUNK_W'(nchunks_raw);
    end
  end

  // Divider operands
  always_comb begin
    unique case (cmd.div_op)
      DIV_BITS_BY_CHUNKS: begin
        div_a = DIV_W'(nb);
        div_b = DIV_W'(nc);
      end
      DIV_BITS_BY_SIZE: begin
        div_a = DIV_W'(nb);
        div_b = DIV_W'(cb);
      end
      DIV_POS_BY_SIZE: begin
        div_a = DIV_W'(pos_q);
        div_b = DIV_W'(cb);
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
    ceil_q = quot + DIV_W'(rem != '0);
  end

  bzr_div #(
    .WIDTH (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // Count zeros in the part of the current byte that lies before the segment end
  always_comb begin
    byte_base  = {p[BIT_W-1:LANE_W], {LANE_W{1'b0}}};
    seg_top    = (BIT_W+1)'(byte_base) + (BIT_W+1)'(BYTE_W);
    q_x        = (seg_top < {1'b0, lim}) ? seg_top : {1'b0, lim};
    q          = q_x[BIT_W-1:0];
    lane       = p[LANE_W-1:0];
    span       = SPAN_W'(q_x - (BIT_W+1)'(byte_base));
    cnt        = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if ((k >= int'(lane)) && (k < int'(span)) && !rd_byte[BYTE_W-1-k]) begin
        cnt = cnt + SPAN_W'(1);
      end
    end
    acc_sum    = acc + BIT_W'(cnt);
    chunk_end  = (q == lim);
    next_lim_x = (BIT_W+1)'(lim) + (BIT_W+1)'(cb);
    next_lim   = (next_lim_x < (BIT_W+1)'(nb)) ? next_lim_x[BIT_W-1:0] : nb;
    chunk_write = cmd.step && chunk_end && (func_q == FUNC_BUILD);
  end

  // Prefix table addressing
  always_comb begin
    pf_we    = cmd.build_init || chunk_write;
    pf_waddr = cmd.build_init ? '0 : ci + CHUNK_W'(1);
    pf_wdata = cmd.build_init ? '0 : acc_sum;
    unique case (cmd.pf_sel)
      PF_RANK:     pf_raddr = CHUNK_W'(quot);
      PF_CHUNK_HI: pf_raddr = CHUNK_W'(cidx_q) + CHUNK_W'(1);
      PF_CHUNK_LO: pf_raddr = CHUNK_W'(cidx_q);
      default:     pf_raddr = '0;
    endcase
  end

  // Result count source
  always_comb begin
    unique case (cmd.out_sel)
      OUT_ACC:  out_val = acc;
      OUT_DIFF: out_val = hold - pf_rd;
      OUT_ZERO: out_val = '0;
      default:  out_val = '0;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.accept && (func == FUNC_LOAD) && (32'(byte_index) < 32'(STORE_BYTES))) begin
      byte_mem[BADDR_W'(byte_index)] <= byte_value;
    end
    if (cmd.byte_read) begin
      rd_byte <= byte_mem[BADDR_W'(p >> LANE_W)];
    end
  end

  always_ff @(posedge clk) begin
    if (pf_we) begin
      pf_mem[pf_waddr] <= pf_wdata;
    end
    if (cmd.pf_read) begin
      pf_rd <= pf_mem[pf_raddr];
    end
  end

  // Configuration and build results
  always_ff @(posedge clk) begin
    if (rst) begin
      nb    <= BIT_W'(NB_RESET);
      nc    <= CHUNK_W'(1);
      cb    <= '0;
      total <= '0;
      built <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        built <= 1'b0;
        if (cfg_index == CFG_N_BITS) begin
          nb <= nb_new;
        end else begin
          nc <= nc_new;
        end
      end
      if (cmd.set_size) begin
        cb <= BIT_W'(ceil_q);
      end
      if (cmd.set_total) begin
        total <= CHUNK_W'(ceil_q);
      end
      if (cmd.set_built) begin
        built <= 1'b1;
      end
    end
  end

  // Item capture, sweep and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func_t'(func);
      pos_q  <= pos;
      cidx_q <= chunk_index;
    end
    if (cmd.build_init) begin
      p   <= '0;
      lim <= cb;
      acc <= '0;
      ci  <= '0;
    end
    if (cmd.rank_init) begin
      p   <= BIT_W'(pos_q) - BIT_W'(rem);
      lim <= BIT_W'(pos_q);
    end
    if (cmd.acc_load) begin
      acc <= pf_rd;
    end
    if (cmd.step) begin
      p   <= q;
      acc <= acc_sum;
      if (chunk_write) begin
        ci  <= ci + CHUNK_W'(1);
        lim <= next_lim;
      end
    end
    if (cmd.hold_load) begin
      hold <= pf_rd;
    end
    if (cmd.out_load) begin
      zero_count <= COUNT_W'(out_val);
      status     <= cmd.out_status;
    end
  end

  // Status towards the controller
  always_comb begin
    stat.func        = func_q;
    stat.built       = built;
    stat.pos_bad     = 32'(pos_q) > 32'(nb);
    stat.chunk_bad   = 32'(cidx_q) >= 32'(total);
    stat.div_done    = div_done;
    stat.sweep_empty = (p == lim);
    stat.step_final  = chunk_end && ((func_q != FUNC_BUILD) || (lim == nb));
  end

endmodule

/* src/bzr_ctrl.sv */
module bzr_ctrl
  import bzr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [FUNC_W-1:0] func,
  input  logic              cfg_valid,
  input  logic              rsp_stall,
  input  bzr_stat_t         stat,
  output logic              req_stall,
  output logic              rsp_valid,
  output logic              cfg_ready,
  output bzr_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BDIV1,
    S_BWAIT1,
    S_BDIV2,
    S_BWAIT2,
    S_BINIT,
    S_READ,
    S_COUNT,
    S_CHECK,
    S_QDIV,
    S_QWAIT,
    S_QPREFIX,
    S_CHI,
    S_CLO,
    S_DONE
  } state_t;

  state_t   state;
  state_t   state_next;
  out_sel_t res_sel;
  out_sel_t res_sel_next;
  status_t  res_code;
  status_t  res_code_next;
  logic     rsp_valid_next;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Sequence the commands for each kind of item
  always_comb begin
    cmd            = '0;
    cmd.out_sel    = res_sel;
    cmd.out_status = res_code;
    cmd.cfg_write  = cfg_valid && (state == S_IDLE);
    state_next     = state;
    res_sel_next   = res_sel;
    res_code_next  = res_code;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          priority if (func == FUNC_BUILD) begin
            state_next = S_BDIV1;
          end else if (func != FUNC_LOAD) begin
            state_next = S_CHECK;
          end else begin
            // A load completes on its transfer
            state_next = S_IDLE;
          end
        end
      end
      S_BDIV1: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_BITS_BY_CHUNKS;
        state_next    = S_BWAIT1;
      end
      S_BWAIT1: begin
        cmd.div_op = DIV_BITS_BY_CHUNKS;
        if (stat.div_done) begin
          cmd.set_size = 1'b1;
          state_next   = S_BDIV2;
        end
      end
      S_BDIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_BITS_BY_SIZE;
        state_next    = S_BWAIT2;
      end
      S_BWAIT2: begin
        cmd.div_op = DIV_BITS_BY_SIZE;
        if (stat.div_done) begin
          cmd.set_total = 1'b1;
          state_next    = S_BINIT;
        end
      end
      S_BINIT: begin
        cmd.build_init = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        cmd.byte_read = 1'b1;
        state_next    = S_COUNT;
      end
      S_COUNT: begin
        cmd.step = 1'b1;
        if (stat.step_final) begin
          if (stat.func == FUNC_BUILD) begin
            cmd.set_built = 1'b1;
            state_next    = S_IDLE;
          end else begin
            res_sel_next  = OUT_ACC;
            res_code_next = ST_OK;
            state_next    = S_DONE;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_CHECK: begin
        res_sel_next = OUT_ZERO;
        priority if (!stat.built) begin
          res_code_next = ST_NOT_BUILT;
          state_next    = S_DONE;
        end else if (stat.func == FUNC_RANK) begin
          if (stat.pos_bad) begin
            res_code_next = ST_POS_RANGE;
            state_next    = S_DONE;
          end else begin
            state_next = S_QDIV;
          end
        end else if (stat.chunk_bad) begin
          res_code_next = ST_CHUNK_RANGE;
          state_next    = S_DONE;
        end else begin
          state_next = S_CHI;
        end
      end
      S_QDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DIV_POS_BY_SIZE;
        state_next    = S_QWAIT;
      end
      S_QWAIT: begin
        cmd.div_op = DIV_POS_BY_SIZE;
        if (stat.div_done) begin
          cmd.rank_init = 1'b1;
          cmd.pf_read   = 1'b1;
          cmd.pf_sel    = PF_RANK;
          state_next    = S_QPREFIX;
        end
      end
      S_QPREFIX: begin
        cmd.acc_load = 1'b1;
        if (stat.sweep_empty) begin
          res_sel_next  = OUT_ACC;
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_CHI: begin
        cmd.pf_read = 1'b1;
        cmd.pf_sel  = PF_CHUNK_HI;
        state_next  = S_CLO;
      end
      S_CLO: begin
        cmd.pf_read   = 1'b1;
        cmd.pf_sel    = PF_CHUNK_LO;
        cmd.hold_load = 1'b1;
        res_sel_next  = OUT_DIFF;
        res_code_next = ST_OK;
        state_next    = S_DONE;
      end
      S_DONE: begin
        // Wait until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  // Output register valid: set on load, drop on transfer
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      res_sel   <= OUT_ZERO;
      res_code  <= ST_OK;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      res_sel   <= res_sel_next;
      res_code  <= res_code_next;
    end
  end

endmodule

/* src/bitmap_zero_rank_chunked_core.sv */
// Load: completes on its transfer; the next item may follow at once.
// Chunk count query: a range check, two prefix table reads, then the result load.
// Rank query: pos divided by the chunk size in the divider (17 bits wide by default),
// a prefix table read, then a byte sweep from the chunk start to pos, which reads
// one byte and then counts its zeros. Build: two divisions, then a sweep of all bytes.
// Synchronous rst restores 65536 valid bits, one requested chunk and clears the built
// flag; the bitmap and prefix memories keep their contents and need no clearing pass.
module bitmap_zero_rank_chunked_core
  import bzr_pkg::*;
#(
  parameter int MAX_BITS   = DEF_MAX_BITS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [FUNC_W-1:0]      func,
  input  logic [BIDX_W-1:0]      byte_index,
  input  logic [BYTE_W-1:0]      byte_value,
  input  logic [POS_W-1:0]       pos,
  input  logic [CIDX_W-1:0]      chunk_index,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [COUNT_W-1:0]     zero_count,
  output logic [STATUS_W-1:0]    status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  bzr_cmd_t  cmd;
  bzr_stat_t stat;

  bzr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .func      (func),
    .cfg_valid (cfg_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bzr_dp #(
    .MAX_BITS   (MAX_BITS),
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (func),
    .byte_index  (byte_index),
    .byte_value  (byte_value),
    .pos         (pos),
    .chunk_index (chunk_index),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .zero_count  (zero_count),
    .status      (status)
  );

endmodule

/* src/bzr_checker.sv */
module bzr_checker
  import bzr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic [FUNC_W-1:0]   func,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [COUNT_W-1:0]  zero_count,
  input logic [STATUS_W-1:0] status
);

  // A stalled result holds until its transfer
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(zero_count) && $stable(status))
    else $error("result changed while stalled");

  // An error result carries no count
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> zero_count == '0)
    else $error("error result with non-zero count");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (func == FUNC_LOAD) && !rsp_valid |=> !rsp_valid)
    else $error("result appeared after a load");

  // Any other item keeps the block busy in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (func != FUNC_LOAD) |=> req_stall)
    else $error("input taken again straight after a multi-cycle item");

endmodule

bind bitmap_zero_rank_chunked_core bzr_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .func       (func),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .zero_count (zero_count),
  .status     (status)
);
